FILE: rtl/atma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix accumulator package
// Shared types, operation codes, angle constants and the arctangent table.
// ----------------------------------------------------------------------------
package atma_pkg;

   localparam int ELEM_W = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W  = 66;
   localparam int XY_W   = 34;
   localparam int Z_W    = 25;

   localparam logic [2:0] OP_IDENTITY  = 3'd0;
   localparam logic [2:0] OP_ROTATE    = 3'd1;
   localparam logic [2:0] OP_SCALE     = 3'd2;
   localparam logic [2:0] OP_TRANSLATE = 3'd3;
   localparam logic [2:0] OP_REFLECT   = 3'd4;

   // Angle constants in 1/64 degree units.
   localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

   // CORDIC gain in Q30.
   localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic                     done;
      logic signed [ELEM_W-1:0] sin_val;
      logic signed [ELEM_W-1:0] cos_val;
   } cordic_out_type;

   // atan(2^-i) in units of 2^-16 degree.
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:  val = 25'sd2949120;
         5'd1:  val = 25'sd1740967;
         5'd2:  val = 25'sd919879;
         5'd3:  val = 25'sd466945;
         5'd4:  val = 25'sd234379;
         5'd5:  val = 25'sd117304;
         5'd6:  val = 25'sd58666;
         5'd7:  val = 25'sd29335;
         5'd8:  val = 25'sd14668;
         5'd9:  val = 25'sd7334;
         5'd10: val = 25'sd3667;
         5'd11: val = 25'sd1833;
         5'd12: val = 25'sd917;
         5'd13: val = 25'sd458;
         5'd14: val = 25'sd229;
         5'd15: val = 25'sd115;
         5'd16: val = 25'sd57;
         5'd17: val = 25'sd29;
         5'd18: val = 25'sd14;
         5'd19: val = 25'sd7;
         5'd20: val = 25'sd4;
         5'd21: val = 25'sd2;
         5'd22: val = 25'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/atma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix accumulator channels
// Operation request channel and matrix row response channel.
// ----------------------------------------------------------------------------
interface atma_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [15:0] angle_degrees;
   logic signed [31:0] arg_first;
   logic signed [31:0] arg_second;
   logic               flip_vertical;

   modport source (output valid, operation, angle_degrees, arg_first, arg_second,
                   flip_vertical, input ready);
   modport sink (input valid, operation, angle_degrees, arg_first, arg_second,
                 flip_vertical, output ready);
endinterface

interface atma_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row_index;
   logic signed [31:0] col_zero;
   logic signed [31:0] col_one;
   logic signed [31:0] col_two;
   logic signed [31:0] col_three;
   logic               last_row;
   logic               saturated;

   modport source (output valid, row_index, col_zero, col_one, col_two, col_three,
                   last_row, saturated, input ready);
   modport sink (input valid, row_index, col_zero, col_one, col_two, col_three,
                 last_row, saturated, output ready);
endinterface

FILE: rtl/atma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module atma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/atma_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// Reduces a 1/64 degree angle to +-90 degrees, then one rotation per cycle.
// ----------------------------------------------------------------------------
module atma_cordic #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [15:0]    angle,
   output atma_pkg::cordic_out_type result
);
   import atma_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);

   logic signed [16:0]     a_ext, r_mod, r_half, r_fold;
   logic                   fold_neg;
   logic signed [XY_W-1:0] x_ff, y_ff, x_in, y_in, dx, dy, xf, yf;
   logic signed [Z_W-1:0]  z_ff, z_in, at;
   logic [IW-1:0]          i_ff;
   logic                   run_ff, neg_ff, done_ff;
   logic signed [ELEM_W-1:0] sin_ff, cos_ff;

   // Range reduction into (-180, 180], then fold beyond a quarter turn.
   always_comb begin
      a_ext = {angle[15], angle};
      if (a_ext >= FULL_TURN) begin
         r_mod = a_ext - FULL_TURN;
      end else if (a_ext < 0) begin
         r_mod = a_ext + FULL_TURN;
         if (r_mod < 0) begin
            r_mod = r_mod + FULL_TURN;
         end
      end else begin
         r_mod = a_ext;
      end
      r_half   = (r_mod > HALF_TURN) ? r_mod - FULL_TURN : r_mod;
      r_fold   = r_half;
      fold_neg = 1'b0;
      if (r_half > QUARTER_TURN) begin
         r_fold   = r_half - HALF_TURN;
         fold_neg = 1'b1;
      end else if (r_half < -QUARTER_TURN) begin
         r_fold   = r_half + HALF_TURN;
         fold_neg = 1'b1;
      end
   end

   always_comb begin
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = atan_entry(5'(i_ff));
      if (z_ff >= 0) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
      xf = neg_ff ? -x_in : x_in;
      yf = neg_ff ? -y_in : y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && i_ff == IW'(CORDIC_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= GAIN_Q30;
         y_ff   <= '0;
         z_ff   <= {{(Z_W - 17){r_fold[16]}}, r_fold} <<< 10;
         neg_ff <= fold_neg;
         i_ff   <= '0;
      end else if (run_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         i_ff <= i_ff + 1'b1;
         if (i_ff == IW'(CORDIC_STEPS - 1)) begin
            cos_ff <= ELEM_W'(xf >>> (30 - FRAC_BITS));
            sin_ff <= ELEM_W'(yf >>> (30 - FRAC_BITS));
         end
      end
   end

   assign result.done    = done_ff;
   assign result.sin_val = sin_ff;
   assign result.cos_val = cos_ff;
endmodule

FILE: rtl/affine_transform_matrix_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine transform matrix accumulator core
// Keeps a 4x4 Q fixed point matrix and post-multiplies it by each operation.
// ----------------------------------------------------------------------------
// Each row is read, multiply-accumulated for its two changing columns, written back
// and emitted; scale, translate and reflect take these steps. A rotate first waits
// for the CORDIC result. Identity and unknown codes skip the arithmetic: each row
// is only read and emitted.
// One operation at a time; the 32x32 multiplier is shared and response stalls add cycles.
// Synchronous reset restores the identity matrix at once through valid bits.
module affine_transform_matrix_accumulator_core #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input logic        clock,
   input logic        reset,
   atma_req_if.sink   req_ch,
   atma_rsp_if.source rsp_ch
);
   import atma_pkg::*;

   localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(1) <<< FRAC_BITS;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ANGLE = 6'b000010,
      ST_READ  = 6'b000100,
      ST_MAC   = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       col_ff, col_in;

   // Latched operation.
   logic [2:0]               op_ff;
   logic signed [ELEM_W-1:0] a1_ff, a2_ff;
   logic                     flip_ff, apply_ff;

   // Row datapath.
   logic signed [ELEM_W-1:0] elem_ff [4];
   logic signed [ELEM_W-1:0] res_ff [2];
   logic                     sat_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, shifted;
   logic signed [ELEM_W-1:0] t_elem, sat_val;
   logic                     ovf;
   logic [15:0]              valid_ff;
   logic                     rd_valid_ff;
   logic [1:0]               km1;

   // Matrix memory ports.
   logic                ram_we;
   logic [3:0]          ram_waddr, ram_raddr;
   logic [ELEM_W-1:0]   ram_wdata, ram_rdata;

   // Response output register.
   logic                     rsp_valid_ff, rsp_last_ff, rsp_sat_ff, emit_load;
   logic [1:0]               rsp_row_ff;
   logic signed [ELEM_W-1:0] rsp_col_ff [4];

   cordic_out_type cord;
   logic           req_fire, cord_start;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign cord_start   = req_fire && (req_ch.operation == OP_ROTATE);
   assign emit_load    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   atma_cordic #(
      .FRAC_BITS   (FRAC_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .angle (req_ch.angle_degrees),
      .result(cord)
   );

   // Reads of a row always finish before its two updated elements are written,
   // and the next row is read only afterwards, so no forwarding is needed.
   atma_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(16)
   ) u_matrix (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign ram_raddr = {row_ff, cnt_ff[1:0]};
   assign ram_we    = (state_ff == ST_WRITE);
   assign ram_waddr = {row_ff, 1'b0, cnt_ff[0]};
   assign ram_wdata = res_ff[cnt_ff[0]];
   assign km1       = 2'(cnt_ff - 3'd1);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            cnt_in = '0;
            if (req_fire) begin
               state_in = (req_ch.operation == OP_ROTATE) ? ST_ANGLE : ST_READ;
            end
         end
         ST_ANGLE: begin
            if (cord.done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               col_in   = 1'b0;
               state_in = apply_ff ? ST_MAC : ST_EMIT;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               cnt_in = '0;
               col_in = 1'b1;
               if (col_ff) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               cnt_in = '0;
               if (row_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Transform element T[k][j] for the two columns that can change. Columns
   // two and three of every transform are identity columns, so they stay.
   always_comb begin
      t_elem = '0;
      case (op_ff)
         OP_ROTATE: begin
            if (cnt_ff[1:0] == 2'd0) begin
               t_elem = col_ff ? cord.sin_val : cord.cos_val;
            end else if (cnt_ff[1:0] == 2'd1) begin
               t_elem = col_ff ? cord.cos_val : -cord.sin_val;
            end
         end
         OP_SCALE: begin
            if (cnt_ff[1:0] == 2'd0 && !col_ff) begin
               t_elem = a1_ff;
            end else if (cnt_ff[1:0] == 2'd1 && col_ff) begin
               t_elem = a2_ff;
            end
         end
         OP_TRANSLATE: begin
            if (cnt_ff[1:0] == 2'd0 && !col_ff) begin
               t_elem = ONE;
            end else if (cnt_ff[1:0] == 2'd1 && col_ff) begin
               t_elem = ONE;
            end else if (cnt_ff[1:0] == 2'd3) begin
               t_elem = col_ff ? a2_ff : a1_ff;
            end
         end
         OP_REFLECT: begin
            if (cnt_ff[1:0] == 2'd0 && !col_ff) begin
               t_elem = flip_ff ? -ONE : ONE;
            end else if (cnt_ff[1:0] == 2'd1 && col_ff) begin
               t_elem = flip_ff ? ONE : -ONE;
            end
         end
         default: begin
            t_elem = '0;
         end
      endcase
   end

   // The exact four-product sum is floored by the fraction shift, then
   // clamped to the 32-bit range.
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      ovf     = !((&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]));
      if (ovf) begin
         sat_val = shifted[ACC_W-1] ? ELEM_MIN : ELEM_MAX;
      end else begin
         sat_val = shifted[ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         cnt_ff       <= '0;
         col_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         if (req_fire && req_ch.operation == OP_IDENTITY) begin
            valid_ff <= '0;
         end else if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_ch.operation;
         a1_ff    <= req_ch.arg_first;
         a2_ff    <= req_ch.arg_second;
         flip_ff  <= req_ch.flip_vertical;
         apply_ff <= (req_ch.operation == OP_ROTATE) || (req_ch.operation == OP_SCALE) ||
                     (req_ch.operation == OP_TRANSLATE) || (req_ch.operation == OP_REFLECT);
      end
      rd_valid_ff <= valid_ff[ram_raddr];
      if (state_ff == ST_READ) begin
         sat_ff <= 1'b0;
         if (cnt_ff != 3'd0) begin
            // An entry never written since the last identity reads as identity.
            if (rd_valid_ff) begin
               elem_ff[km1] <= ram_rdata;
            end else begin
               elem_ff[km1] <= (km1 == row_ff) ? ONE : '0;
            end
         end
      end
      if (state_ff == ST_MAC) begin
         if (cnt_ff < 3'd4) begin
            prod_ff <= elem_ff[cnt_ff[1:0]] * t_elem;
         end
         if (cnt_ff == 3'd1) begin
            acc_ff <= ACC_W'(prod_ff);
         end else if (cnt_ff != 3'd0 && cnt_ff != 3'd5) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         if (cnt_ff == 3'd5) begin
            res_ff[col_ff] <= sat_val;
            sat_ff         <= sat_ff | ovf;
         end
      end
      if (state_ff == ST_WRITE) begin
         elem_ff[{1'b0, cnt_ff[0]}] <= res_ff[cnt_ff[0]];
      end
      if (emit_load) begin
         rsp_row_ff <= row_ff;
         rsp_col_ff <= elem_ff;
         rsp_last_ff <= (row_ff == 2'd3);
         rsp_sat_ff <= sat_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_row_ff;
   assign rsp_ch.col_zero  = rsp_col_ff[0];
   assign rsp_ch.col_one   = rsp_col_ff[1];
   assign rsp_ch.col_two   = rsp_col_ff[2];
   assign rsp_ch.col_three = rsp_col_ff[3];
   assign rsp_ch.last_row  = rsp_last_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // The CORDIC only finishes while the sequencer waits for it.
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cord.done |-> state_ff == ST_ANGLE)
      else $error("CORDIC finished outside the angle wait");

   // An identity operation invalidates every stored entry.
   a_identity_clear: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.operation == OP_IDENTITY) |=> valid_ff == '0)
      else $error("identity did not clear the matrix");

   // Multiply passes happen only for operations that change the matrix.
   a_mac_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> apply_ff)
      else $error("multiply pass on a non-transform operation");

endmodule

FILE: dv/affine_transform_matrix_accumulator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine transform matrix accumulator core testbench
// Drives random and directed matrix operations with random idling on both
// channels and checks every emitted row against a behavioral matrix model.
// ----------------------------------------------------------------------------
module affine_transform_matrix_accumulator_core_test;
   import atma_pkg::*;

   typedef struct {
      logic [2:0]         operation;
      logic signed [15:0] angle_degrees;
      logic signed [31:0] arg_first;
      logic signed [31:0] arg_second;
      logic               flip_vertical;
   } op_beat_type;

   typedef struct {
      logic [1:0]         row_index;
      logic signed [31:0] col [4];
      logic               last_row;
      logic               saturated;
   } row_beat_type;

   localparam int QF = 16;
   localparam int STEPS = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   atma_req_if req_ch ();
   atma_rsp_if rsp_ch ();

   affine_transform_matrix_accumulator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   op_beat_type  pending_ops[$];
   row_beat_type expected_rows[$];
   logic signed [31:0] model_mat [16];

   int mismatches = 0;
   int rows_seen  = 0;
   int ops_sent   = 0;
   bit hold_for_drain = 1'b0;

   // Floor shift: arithmetic right shift of a signed value is floor division.
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void model_identity(ref logic signed [31:0] m [16]);
      for (int i = 0; i < 16; i++)
         m[i] = ((i & 3) == (i >> 2)) ? 32'sd65536 : 32'sd0;
   endfunction

   // CORDIC sine and cosine from an angle in 1/64 degree units.
   function automatic void model_sincos(longint ang, output logic signed [31:0] s,
                                        output logic signed [31:0] c);
      longint r, x, y, z, dx, dy;
      bit neg;
      r = ang % 23040;
      neg = 1'b0;
      if (r < 0) r += 23040;
      if (r > 11520) r -= 23040;
      if (r > 5760) begin
         r -= 11520; neg = 1'b1;
      end else if (r < -5760) begin
         r += 11520; neg = 1'b1;
      end
      x = 652032874; y = 0; z = r * 1024;
      for (int i = 0; i < STEPS; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = 32'(fshift(x, 30 - QF));
      s = 32'(fshift(y, 30 - QF));
   endfunction

   // Applies one operation to the model matrix and queues the four rows.
   task automatic predict_rows(op_beat_type op);
      logic signed [31:0] t [16];
      logic signed [31:0] s, c;
      logic signed [31:0] res [4];
      longint hi, lo, p, v;
      bit apply;
      bit sat [4];
      row_beat_type rb;
      model_identity(t);
      apply = 1'b1;
      for (int r = 0; r < 4; r++) sat[r] = 1'b0;
      case (op.operation)
         OP_IDENTITY: begin
            model_identity(model_mat); apply = 1'b0;
         end
         OP_ROTATE: begin
            model_sincos(longint'(op.angle_degrees), s, c);
            t[0] = c; t[5] = c; t[1] = s; t[4] = 32'(-longint'(s));
         end
         OP_SCALE: begin
            t[0] = op.arg_first; t[5] = op.arg_second;
         end
         OP_TRANSLATE: begin
            t[12] = op.arg_first; t[13] = op.arg_second;
         end
         OP_REFLECT: begin
            t[0] = op.flip_vertical ? -32'sd65536 : 32'sd65536;
            t[5] = op.flip_vertical ? 32'sd65536 : -32'sd65536;
         end
         default: apply = 1'b0;
      endcase
      if (apply) begin
         for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
               hi = 0; lo = 0;
               for (int k = 0; k < 4; k++) begin
                  p = longint'(model_mat[r*4+k]) * longint'(t[k*4+j]);
                  hi += fshift(p, QF);
                  lo += p & 64'h0000_0000_0000_ffff;
               end
               v = hi + fshift(lo, QF);
               if (v > 64'sd2147483647) begin
                  v = 64'sd2147483647; sat[r] = 1'b1;
               end else if (v < -64'sd2147483648) begin
                  v = -64'sd2147483648; sat[r] = 1'b1;
               end
               res[j] = 32'(v);
            end
            for (int j = 0; j < 4; j++) model_mat[r*4+j] = res[j];
         end
      end
      for (int r = 0; r < 4; r++) begin
         rb.row_index = 2'(r);
         for (int j = 0; j < 4; j++) rb.col[j] = model_mat[r*4+j];
         rb.last_row = (r == 3);
         rb.saturated = sat[r];
         expected_rows.push_back(rb);
      end
   endtask

   // Driver: one beat per pending operation, with a random gap before each.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.operation     <= OP_IDENTITY;
         req_ch.angle_degrees <= '0;
         req_ch.arg_first     <= '0;
         req_ch.arg_second    <= '0;
         req_ch.flip_vertical <= 1'b0;
         send_gap <= $urandom_range(0, 19);
      end else if (req_ch.valid && req_ch.ready) begin
         predict_rows(op_beat_type'{req_ch.operation, req_ch.angle_degrees,
                                    req_ch.arg_first, req_ch.arg_second,
                                    req_ch.flip_vertical});
         ops_sent <= ops_sent + 1;
         req_ch.valid <= 1'b0;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end else if (!req_ch.valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_ops.size() > 0 &&
                      !(hold_for_drain && expected_rows.size() > 0)) begin
            op_beat_type op;
            op = pending_ops.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.operation     <= op.operation;
            req_ch.angle_degrees <= op.angle_degrees;
            req_ch.arg_first     <= op.arg_first;
            req_ch.arg_second    <= op.arg_second;
            req_ch.flip_vertical <= op.flip_vertical;
         end
      end
   end

   // Monitor: compares each accepted row beat with the oldest expectation.
   int recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            row_beat_type e;
            rows_seen <= rows_seen + 1;
            if (expected_rows.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected row beat: row %0d", rsp_ch.row_index);
            end else begin
               e = expected_rows.pop_front();
               if (e.row_index !== rsp_ch.row_index || e.col[0] !== rsp_ch.col_zero ||
                   e.col[1] !== rsp_ch.col_one || e.col[2] !== rsp_ch.col_two ||
                   e.col[3] !== rsp_ch.col_three || e.last_row !== rsp_ch.last_row ||
                   e.saturated !== rsp_ch.saturated) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("row mismatch: exp r%0d %h %h %h %h l%b s%b",
                            e.row_index, e.col[0], e.col[1], e.col[2], e.col[3],
                            e.last_row, e.saturated);
                     $display(" got r%0d %h %h %h %h l%b s%b",
                              rsp_ch.row_index, rsp_ch.col_zero, rsp_ch.col_one,
                              rsp_ch.col_two, rsp_ch.col_three,
                              rsp_ch.last_row, rsp_ch.saturated);
                  end
               end
            end
            rsp_ch.ready <= 1'b0;
            recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end else if (!rsp_ch.ready) begin
            if (recv_gap > 0) recv_gap <= recv_gap - 1;
            else rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [31:0] rand_arg();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7fff_ffff;
         2: return 32'sh8000_0000;
         default: return $signed(32'($urandom_range(0, 196608))) - 32'sd98304;
      endcase
   endfunction

   task automatic add_op(logic [2:0] op, logic signed [15:0] ang, logic signed [31:0] a1,
                         logic signed [31:0] a2, logic fv);
      pending_ops.push_back(op_beat_type'{op, ang, a1, a2, fv});
   endtask

   initial begin
      op_beat_type op;
      model_identity(model_mat);

      // Directed: each operation, angle folds and wraps, saturating extremes,
      // and the undefined codes.
      add_op(OP_IDENTITY, 16'sd0, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, 16'sd5760, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, -16'sd5760, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, 16'sd11520, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, -16'sd23040, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, 16'sd23040, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, 16'sh7fff, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, 16'sh8000, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_ROTATE, 16'sd7000, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_REFLECT, 16'sd0, 32'sd0, 32'sd0, 1'b1);
      add_op(OP_REFLECT, 16'sd0, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_TRANSLATE, 16'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      add_op(OP_TRANSLATE, 16'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      add_op(OP_SCALE, 16'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
      add_op(OP_SCALE, 16'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      add_op(3'd5, 16'sd0, 32'shffff_ffff, 32'shffff_ffff, 1'b1);
      add_op(3'd6, 16'sd0, 32'sd0, 32'sd0, 1'b0);
      add_op(3'd7, -16'sd1, 32'sd0, 32'sd0, 1'b1);
      add_op(OP_IDENTITY, 16'sd0, 32'sd0, 32'sd0, 1'b0);
      add_op(OP_SCALE, 16'sd0, 32'sd0, 32'sd0, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Let the directed part drain fully before the random part starts.
      wait (pending_ops.size() == 0 && !req_ch.valid);
      hold_for_drain = 1'b1;
      wait (expected_rows.size() == 0);
      hold_for_drain = 1'b0;

      for (int n = 0; n < 450; n++) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 8) op.operation = OP_IDENTITY;
         else if (pick < 35) op.operation = OP_ROTATE;
         else if (pick < 55) op.operation = OP_SCALE;
         else if (pick < 78) op.operation = OP_TRANSLATE;
         else if (pick < 93) op.operation = OP_REFLECT;
         else op.operation = 3'(5 + $urandom_range(0, 2));
         op.angle_degrees = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                            : 16'($signed($urandom_range(0, 46080)) - 23040);
         op.arg_first = rand_arg();
         op.arg_second = rand_arg();
         op.flip_vertical = 1'($urandom_range(0, 1));
         pending_ops.push_back(op);
      end
      wait (pending_ops.size() == 0 && !req_ch.valid);
      wait (expected_rows.size() == 0);
      repeat (200) @(posedge clock);
      $display("run covered %0d operations and %0d row beats with random idling",
               ops_sent, rows_seen);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Timeout for the run of 470 operations with random response stalls and request gaps;
   // it reports the rows still expected.
   initial begin
      #(4 * 1000000);
      $display("timeout with %0d rows still expected", expected_rows.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
